// File: rtl/core/mssu_pkg.sv
// Shared types and constants for the maximum subarray sum segment tree.
package mssu_pkg;

	localparam int MSSU_LEAVES = 1024;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int OUT_W = 41;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DESCEND,
		ST_LEAF,
		ST_READ,
		ST_SUM,
		ST_MERGE,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // write zero at the sweep address
		logic load;     // capture a transaction, start at the root
		logic step;     // descend one level
		logic leaf_wr;  // write the leaf
		logic rd;       // read the sibling of the current node
		logic sum;      // register the merge sums
		logic merge;    // write the parent, move up
		logic out_load; // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic at_leaf;
		logic at_root;
		logic parent_root;
	} sts_t;

endpackage

// File: rtl/core/max_subarray_sum_point_update_top.sv
// Top level: maximum subarray sum over a segment tree with point writes.
//
// Each input transaction writes new_value at index and rebuilds the tree path from that leaf
// to the root; the result transaction carries the root's best subarray sum (empty allowed,
// so never below zero). An index at or beyond LEAVES leaves the tree as it is and returns
// the current best sum. One transaction is worked at a time: with D tree levels
// (D = 10 for 1024 leaves) it descends one level per cycle and, on the way up, does per
// level a read of the sibling from the node memory, a sum step and a compare-and-write
// step.
// A new transaction is taken while the previous result still waits in the output register.
// After reset the node memory of 4*LEAVES entries is cleared one entry per cycle
// and s_tready stays low until that sweep ends.
module max_subarray_sum_point_update_top import mssu_pkg::*; #(
	parameter int LEAVES = MSSU_LEAVES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [9:0] index, [41:10] new_value, [47:42] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // [40:0] best_sum, [47:41] zero
);

	cmd_t             cmd;
	sts_t             sts;
	logic [OUT_W-1:0] best_sum;

	mssu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mssu_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.index     (s_tdata[IDX_W-1:0]),
		.new_value (signed'(s_tdata[IDX_W+VAL_W-1:IDX_W])),
		.best_sum  (best_sum)
	);

	assign m_tdata = {7'b0, best_sum};

`ifndef SYNTH
	// result register is only reloaded once the previous result is gone
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten while a result is pending");

	// one transaction in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while busy");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result raised without an output load");
`endif

endmodule

// File: rtl/core/mssu_ctrl.sv
// Sequencer for clear sweep, tree descent and leaf-to-root rebuild.
module mssu_ctrl import mssu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DESCEND;
				end
			end
			ST_DESCEND: begin
				if (!sts.in_range) begin
					state_d = ST_OUT;
				end else if (sts.at_leaf) begin
					state_d = ST_LEAF;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_LEAF: begin
				cmd.leaf_wr = 1'b1;
				state_d = sts.at_root ? ST_OUT : ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d = sts.parent_root ? ST_OUT : ST_READ;
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: rtl/core/mssu_dp.sv
// Datapath: node memory, descent bounds, merge arithmetic and output register.
module mssu_dp import mssu_pkg::*; #(
	parameter int LEAVES = MSSU_LEAVES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [VAL_W-1:0] new_value,
	output logic [OUT_W-1:0]        best_sum
);

	localparam int LW     = $clog2(LEAVES);
	localparam int PW     = LW + 2;
	localparam int NODES  = 4 * LEAVES;
	localparam int TOT_W  = VAL_W + LW;
	localparam int BEST_W = TOT_W - 1;
	localparam int NODE_W = 3 * BEST_W + TOT_W;
	localparam int CW     = (IDX_W > LW + 1) ? IDX_W : LW + 1;

	logic [NODE_W-1:0] mem [NODES];

	logic [IDX_W-1:0]        idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [LW-1:0]           lo_q, hi_q;
	logic [PW-1:0]           p_q;
	logic [PW-1:0]           clr_q;
	logic [NODE_W-1:0]       rdata_q;
	logic [BEST_W-1:0]       root_q;
	logic [OUT_W-1:0]        out_q;

	// current node summary
	logic [BEST_W-1:0]       cur_pre_q, cur_suf_q, cur_inn_q;
	logic signed [TOT_W-1:0] cur_tot_q;

	// registered merge terms
	logic signed [TOT_W-1:0] s_pre_q, s_suf_q, s_tot_q;
	logic [BEST_W-1:0]       s_mid_q, inn_ab_q, a_pre_q, b_suf_q;

	// descent
	logic [LW:0]   mid_sum;
	logic [LW-1:0] mid;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[LW:1];

	logic go_left;
	assign go_left = CW'(idx_q) <= CW'(mid);

	// leaf values
	logic [BEST_W-1:0]       leaf_c;
	logic signed [TOT_W-1:0] leaf_tot;
	assign leaf_c   = val_q[VAL_W-1] ? '0 : BEST_W'(unsigned'(val_q));
	assign leaf_tot = TOT_W'(val_q);

	// sibling summary
	logic [BEST_W-1:0]       sib_pre, sib_suf, sib_inn;
	logic signed [TOT_W-1:0] sib_tot;
	assign {sib_pre, sib_suf, sib_tot, sib_inn} = rdata_q;

	// A is the left child, B the right one
	logic [BEST_W-1:0]       a_pre, a_suf, a_inn, b_pre, b_suf, b_inn;
	logic signed [TOT_W-1:0] a_tot, b_tot;
	always_comb begin
		if (!p_q[0]) begin
			a_pre = cur_pre_q; a_suf = cur_suf_q; a_tot = cur_tot_q; a_inn = cur_inn_q;
			b_pre = sib_pre;   b_suf = sib_suf;   b_tot = sib_tot;   b_inn = sib_inn;
		end else begin
			a_pre = sib_pre;   a_suf = sib_suf;   a_tot = sib_tot;   a_inn = sib_inn;
			b_pre = cur_pre_q; b_suf = cur_suf_q; b_tot = cur_tot_q; b_inn = cur_inn_q;
		end
	end

	logic [BEST_W:0] mid_w;
	assign mid_w = {1'b0, a_suf} + {1'b0, b_pre};

	// merge results; the prefix and suffix terms are already nonnegative
	logic [BEST_W-1:0] m_pre, m_suf, m_inn;
	assign m_pre = (s_pre_q > signed'({1'b0, a_pre_q})) ? s_pre_q[BEST_W-1:0] : a_pre_q;
	assign m_suf = (s_suf_q > signed'({1'b0, b_suf_q})) ? s_suf_q[BEST_W-1:0] : b_suf_q;
	assign m_inn = (s_mid_q > inn_ab_q) ? s_mid_q : inn_ab_q;

	// write port
	logic              we;
	logic [PW-1:0]     waddr;
	logic [NODE_W-1:0] wdata;
	logic [BEST_W-1:0] winn;
	always_comb begin
		we    = cmd.clear | cmd.leaf_wr | cmd.merge;
		waddr = clr_q;
		wdata = '0;
		winn  = '0;
		if (cmd.leaf_wr) begin
			waddr = p_q;
			winn  = leaf_c;
			wdata = {leaf_c, leaf_c, leaf_tot, leaf_c};
		end else if (cmd.merge) begin
			waddr = p_q >> 1;
			winn  = m_inn;
			wdata = {m_pre, m_suf, s_tot_q, m_inn};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[p_q ^ PW'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			root_q <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + PW'(1);
			end
			if ((cmd.leaf_wr || cmd.merge) && waddr == PW'(1)) begin
				root_q <= winn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= index;
			val_q <= new_value;
			lo_q  <= '0;
			hi_q  <= LW'(LEAVES - 1);
			p_q   <= PW'(1);
		end else if (cmd.step) begin
			if (go_left) begin
				hi_q <= mid;
				p_q  <= {p_q[PW-2:0], 1'b0};
			end else begin
				lo_q <= mid + LW'(1);
				p_q  <= {p_q[PW-2:0], 1'b1};
			end
		end else if (cmd.merge) begin
			p_q <= p_q >> 1;
		end

		if (cmd.leaf_wr) begin
			cur_pre_q <= leaf_c;
			cur_suf_q <= leaf_c;
			cur_tot_q <= leaf_tot;
			cur_inn_q <= leaf_c;
		end else if (cmd.merge) begin
			cur_pre_q <= m_pre;
			cur_suf_q <= m_suf;
			cur_tot_q <= s_tot_q;
			cur_inn_q <= m_inn;
		end

		if (cmd.sum) begin
			s_pre_q  <= a_tot + signed'({1'b0, b_pre});
			s_suf_q  <= signed'({1'b0, a_suf}) + b_tot;
			s_tot_q  <= a_tot + b_tot;
			s_mid_q  <= mid_w[BEST_W-1:0];
			inn_ab_q <= (a_inn > b_inn) ? a_inn : b_inn;
			a_pre_q  <= a_pre;
			b_suf_q  <= b_suf;
		end
	end

	logic [BEST_W+OUT_W-1:0] root_ext;
	assign root_ext = {{OUT_W{1'b0}}, root_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= root_ext[OUT_W-1:0];
		end
	end

	assign best_sum        = out_q;
	assign sts.clear_last  = clr_q == PW'(NODES - 1);
	assign sts.in_range    = CW'(idx_q) < CW'(LEAVES);
	assign sts.at_leaf     = lo_q == hi_q;
	assign sts.at_root     = p_q == PW'(1);
	assign sts.parent_root = p_q[PW-1:1] == (PW-1)'(1);

endmodule
